FILE: design/cff_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cff_pkg;

    typedef struct packed {
        logic [15:0] load_address;
        logic [15:0] payload_size;
        logic [63:0] name_head;
        logic [23:0] name_tail;
        logic [1:0]  file_type;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
        logic       last;
    } t_item;

    localparam logic [2:0] REG_LOAD_ADDRESS = 3'd0;
    localparam logic [2:0] REG_PAYLOAD_SIZE = 3'd1;
    localparam logic [2:0] REG_NAME_HEAD    = 3'd2;
    localparam logic [2:0] REG_NAME_TAIL    = 3'd3;
    localparam logic [2:0] REG_FILE_TYPE    = 3'd4;

    localparam t_cfg CFG_RESET = '{
        load_address: 16'h6400,
        payload_size: 16'h0001,
        name_head:    64'h2020_2020_2020_2020,
        name_tail:    24'h20_2020,
        file_type:    2'd2
    };

    localparam logic [7:0] MAX_BLOCK_DATA = 8'd223;
    localparam logic [5:0] MAX_RESULTS    = 6'd57;
    localparam logic [5:0] LAST_RESULT    = 6'd56;

    localparam logic [7:0] SYNC_LEAD = 8'hDC;
    localparam logic [7:0] SYNC_FILL = 8'hFF;
    localparam logic [7:0] SYNC_MARK = 8'h01;
    localparam logic [7:0] SYNC_TAIL = 8'h3C;
    localparam logic [7:0] NAME_LEN  = 8'h14;
    localparam logic [7:0] BLK_NAME  = 8'h00;
    localparam logic [7:0] BLK_DATA  = 8'h01;
    localparam logic [7:0] BLK_END   = 8'hFF;

    function automatic logic [7:0] sync_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = SYNC_LEAD;
            4'd12:   b = SYNC_MARK;
            4'd13:   b = SYNC_TAIL;
            default: b = SYNC_FILL;
        endcase
        return b;
    endfunction

    function automatic logic [15:0] size_eff(input logic [15:0] size);
        return (size == 16'd0) ? 16'd1 : size;
    endfunction

endpackage

`default_nettype wire

FILE: design/cff_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cff_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface cff_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       tape_end;
    modport source (output valid, output out_byte, output last_of_run, output tape_end,
                    input ready);
    modport sink (input valid, input out_byte, input last_of_run, input tape_end,
                  output ready);
endinterface

interface cff_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: design/cassette_file_framer.sv
`timescale 1ns / 1ps
`default_nettype none

// An input byte goes through the queue, the back-end state and the output stage.
// Throughput: one tape byte per cycle while the output is ready; an item causes one byte
// for most payload bytes and up to 57 (MAX_RESULTS) for the first and last of a file.
// The sequencer in the back end sets that rate and holds while the output stage is full.
// Reset (synchronous, active low) clears the queue, the file state and the output stage,
// and loads the configuration registers with their default values.

module cassette_file_framer
    import cff_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cff_in_if.sink    i_in,
    cff_out_if.source o_out,
    cff_cfg_if.sink   i_cfg
);

    t_cfg  r_cfg;
    logic  w_push;
    t_item w_push_item;
    logic  w_q_ready;
    logic  w_q_valid;
    t_item w_q_item;
    logic  w_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_LOAD_ADDRESS: r_cfg.load_address <= i_cfg.data[15:0];
                REG_PAYLOAD_SIZE: r_cfg.payload_size <= i_cfg.data[15:0];
                REG_NAME_HEAD:    r_cfg.name_head    <= i_cfg.data;
                REG_NAME_TAIL:    r_cfg.name_tail    <= i_cfg.data[23:0];
                REG_FILE_TYPE:    r_cfg.file_type    <= i_cfg.data[1:0];
                default: ;
            endcase
        end
    end

    cff_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_cfg     (r_cfg),
        .i_q_ready (w_q_ready),
        .o_push    (w_push),
        .o_item    (w_push_item)
    );

    cff_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_pop)
    );

    cff_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

FILE: design/cff_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cff_front
    import cff_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cff_in_if.sink    i_in,
    input  wire t_cfg i_cfg,
    input  wire logic i_q_ready,
    output logic      o_push,
    output t_item     o_item
);

    logic        r_started;
    logic [15:0] r_count;
    logic [15:0] w_count;
    logic [16:0] w_next;
    logic        w_last;

    assign i_in.ready = i_q_ready;
    assign o_push     = i_in.valid && i_q_ready;

    assign w_count = r_started ? r_count : 16'd0;
    assign w_next  = {1'b0, w_count} + 17'd1;
    assign w_last  = w_next >= {1'b0, size_eff(i_cfg.payload_size)};

    assign o_item.data_byte = i_in.data_byte;
    assign o_item.first     = !r_started;
    assign o_item.last      = w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_count   <= 16'd0;
        end else if (o_push) begin
            if (w_last) begin
                r_started <= 1'b0;
                r_count   <= 16'd0;
            end else begin
                r_started <= 1'b1;
                r_count   <= w_next[15:0];
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/cff_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module cff_queue
    import cff_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_ready,
    output logic       o_valid,
    output t_item      o_item,
    input  wire logic  i_pop
);

    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW:0] FULL = (AW + 1)'(DEPTH);

    t_item         r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_fill;

    assign o_ready = r_fill != FULL;
    assign o_valid = r_fill != '0;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: design/cff_back.sv
`timescale 1ns / 1ps
`default_nettype none

module cff_back
    import cff_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_q_valid,
    input  wire t_item i_q_item,
    output logic       o_pop,
    cff_out_if.source  o_out
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NAME = 3'd1;
    localparam logic [2:0] S_HDR  = 3'd2;
    localparam logic [2:0] S_BYTE = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;
    localparam logic [2:0] S_END  = 3'd5;

    localparam logic [1:0] SRC_PRE  = 2'd0;
    localparam logic [1:0] SRC_DATA = 2'd1;
    localparam logic [1:0] SRC_POST = 2'd2;
    localparam logic [1:0] SRC_PAD  = 2'd3;

    localparam logic [5:0] NAME_SUM_START = 6'd15;
    localparam logic [5:0] NAME_SUM_STOP  = 6'd29;
    localparam logic [5:0] NAME_TYPE      = 6'd27;
    localparam logic [5:0] NAME_LAST      = 6'd36;
    localparam logic [5:0] HDR_SYNC_END   = 6'd12;
    localparam logic [5:0] HDR_LAST       = 6'd13;
    localparam logic [5:0] END_SYNC_END   = 6'd14;
    localparam logic [5:0] END_LAST       = 6'd16;
    localparam logic [2:0] AMBLE_LAST     = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [5:0]  r_idx, n_idx;
    logic [1:0]  r_src, n_src;
    logic [2:0]  r_k, n_k;
    logic [16:0] r_pos, n_pos;
    logic [7:0]  r_rem, n_rem;
    logic [7:0]  r_sum, n_sum;
    logic [5:0]  r_cnt, n_cnt;
    logic [7:0]  r_byte, n_byte;
    logic        r_last, n_last;

    logic        r_ovalid;
    logic [7:0]  r_obyte;
    logic        r_olast;
    logic        r_oend;

    logic        w_out_free;
    logic        w_drop;
    logic        w_adv;
    logic [15:0] w_size;
    logic [16:0] w_need;
    logic [16:0] w_limit;
    logic [16:0] w_span;
    logic [16:0] w_total;
    logic [7:0]  w_len;
    logic [7:0]  w_name;
    logic [7:0]  w_sb;
    logic [7:0]  w_endb;
    logic [7:0]  w_emit;
    logic        w_is_end;
    logic        w_step_last;
    logic        w_step;
    logic        w_go_stream;
    logic        w_go_end;
    logic        w_fin;

    assign w_out_free = !r_ovalid || o_out.ready;
    assign w_drop     = r_cnt == MAX_RESULTS;
    assign w_adv      = (r_state != S_IDLE) && (w_drop || w_out_free);
    assign w_size     = size_eff(i_cfg.payload_size);

    always_comb begin
        case (r_src)
            SRC_PRE:  w_need = 17'd11 - {14'd0, r_k};
            SRC_DATA: w_need = 17'd6;
            SRC_POST: w_need = 17'd5 - {14'd0, r_k};
            default:  w_need = 17'd1;
        endcase
    end

    assign w_limit = {1'b0, w_size} + 17'd10;
    assign w_span  = (w_limit > r_pos) ? (w_limit - r_pos) : 17'd0;
    assign w_total = (w_span > w_need) ? w_span : w_need;
    assign w_len   = (w_total > {9'd0, MAX_BLOCK_DATA}) ? MAX_BLOCK_DATA : w_total[7:0];

    always_comb begin
        w_name = 8'h00;
        if (r_idx < 6'd14) begin
            w_name = sync_byte(r_idx[3:0]);
        end else if (r_idx == NAME_SUM_START) begin
            w_name = NAME_LEN;
        end else if (r_idx >= 6'd16 && r_idx <= 6'd23) begin
            w_name = i_cfg.name_head[8 * (7 - int'(r_idx[2:0])) +: 8];
        end else if (r_idx >= 6'd24 && r_idx <= 6'd26) begin
            w_name = i_cfg.name_tail[8 * (2 - int'(r_idx[1:0])) +: 8];
        end else if (r_idx == NAME_TYPE) begin
            w_name = {6'd0, i_cfg.file_type};
        end else if (r_idx == NAME_SUM_STOP) begin
            w_name = 8'hFF;
        end else if (r_idx == NAME_LAST) begin
            w_name = r_sum;
        end
    end

    always_comb begin
        case (r_src)
            SRC_PRE: begin
                case (r_k)
                    3'd1:    w_sb = w_size[15:8];
                    3'd2:    w_sb = w_size[7:0];
                    3'd3:    w_sb = i_cfg.load_address[15:8];
                    3'd4:    w_sb = i_cfg.load_address[7:0];
                    default: w_sb = 8'h00;
                endcase
            end
            SRC_DATA: w_sb = r_byte;
            SRC_POST: begin
                case (r_k)
                    3'd0:    w_sb = 8'hFF;
                    3'd3:    w_sb = i_cfg.load_address[15:8];
                    3'd4:    w_sb = i_cfg.load_address[7:0];
                    default: w_sb = 8'h00;
                endcase
            end
            default: w_sb = 8'h00;
        endcase
    end

    always_comb begin
        if (r_idx < END_SYNC_END) begin
            w_endb = sync_byte(r_idx[3:0]);
        end else if (r_idx == END_SYNC_END || r_idx == END_LAST) begin
            w_endb = BLK_END;
        end else begin
            w_endb = 8'h00;
        end
    end

    always_comb begin
        case (r_state)
            S_NAME: w_emit = w_name;
            S_HDR: begin
                if (r_idx < HDR_SYNC_END) begin
                    w_emit = sync_byte(r_idx[3:0] + 4'd2);
                end else if (r_idx == HDR_SYNC_END) begin
                    w_emit = BLK_DATA;
                end else begin
                    w_emit = w_len;
                end
            end
            S_BYTE:  w_emit = w_sb;
            S_SUM:   w_emit = r_sum;
            S_END:   w_emit = w_endb;
            default: w_emit = 8'h00;
        endcase
    end

    assign w_is_end    = (r_state == S_END) && (r_idx == END_LAST);
    assign w_step_last = w_is_end
                      || ((r_src == SRC_DATA) && !r_last
                          && (((r_state == S_BYTE) && (r_rem != 8'd1)) || (r_state == S_SUM)));

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_src       = r_src;
        n_k         = r_k;
        n_pos       = r_pos;
        n_rem       = r_rem;
        n_sum       = r_sum;
        n_cnt       = r_cnt;
        n_byte      = r_byte;
        n_last      = r_last;
        w_step      = 1'b0;
        w_go_stream = 1'b0;
        w_go_end    = 1'b0;
        w_fin       = 1'b0;
        o_pop       = 1'b0;
        if (w_adv) begin
            if (!w_drop) begin
                n_cnt = r_cnt + 6'd1;
            end
            case (r_state)
                S_NAME: begin
                    if (r_idx == NAME_SUM_START) begin
                        n_sum = NAME_LEN;
                    end else if (r_idx > NAME_SUM_START && r_idx <= NAME_SUM_STOP) begin
                        n_sum = r_sum + w_name;
                    end
                    if (r_idx == NAME_LAST) begin
                        n_pos       = 17'd0;
                        n_rem       = 8'd0;
                        n_sum       = 8'd0;
                        w_go_stream = 1'b1;
                    end else begin
                        n_idx = r_idx + 6'd1;
                    end
                end
                S_HDR: begin
                    if (r_idx == HDR_LAST) begin
                        n_state = S_BYTE;
                        n_rem   = w_len;
                        n_sum   = w_len + 8'd1;
                    end else begin
                        n_idx = r_idx + 6'd1;
                    end
                end
                S_BYTE: begin
                    n_rem = r_rem - 8'd1;
                    n_pos = r_pos + 17'd1;
                    n_sum = r_sum + w_sb;
                    if (r_rem == 8'd1) begin
                        n_state = S_SUM;
                    end else begin
                        w_step = 1'b1;
                    end
                end
                S_SUM: w_step = 1'b1;
                S_END: begin
                    if (r_idx == END_LAST) begin
                        w_fin = 1'b1;
                        n_pos = 17'd0;
                        n_rem = 8'd0;
                        n_sum = 8'd0;
                    end else begin
                        n_idx = r_idx + 6'd1;
                    end
                end
                default: ;
            endcase
            if (w_step) begin
                case (r_src)
                    SRC_PRE: begin
                        if (r_k == AMBLE_LAST) begin
                            n_src = SRC_DATA;
                            n_k   = 3'd0;
                        end else begin
                            n_k = r_k + 3'd1;
                        end
                        w_go_stream = 1'b1;
                    end
                    SRC_DATA: begin
                        if (r_last) begin
                            n_src       = SRC_POST;
                            n_k         = 3'd0;
                            w_go_stream = 1'b1;
                        end else begin
                            w_fin = 1'b1;
                        end
                    end
                    SRC_POST: begin
                        if (r_k != AMBLE_LAST) begin
                            n_k         = r_k + 3'd1;
                            w_go_stream = 1'b1;
                        end else if (n_rem != 8'd0) begin
                            n_src       = SRC_PAD;
                            w_go_stream = 1'b1;
                        end else begin
                            w_go_end = 1'b1;
                        end
                    end
                    default: begin
                        if (n_rem != 8'd0) begin
                            w_go_stream = 1'b1;
                        end else begin
                            w_go_end = 1'b1;
                        end
                    end
                endcase
            end
            if (w_go_stream) begin
                n_state = (n_rem == 8'd0) ? S_HDR : S_BYTE;
                n_idx   = 6'd0;
            end
            if (w_go_end) begin
                n_state = S_END;
                n_idx   = 6'd0;
            end
        end
        if (r_state == S_IDLE || w_fin) begin
            if (i_q_valid) begin
                o_pop  = 1'b1;
                n_byte = i_q_item.data_byte;
                n_last = i_q_item.last;
                n_cnt  = 6'd0;
                n_idx  = 6'd0;
                n_k    = 3'd0;
                if (i_q_item.first) begin
                    n_state = S_NAME;
                    n_src   = SRC_PRE;
                end else begin
                    n_src   = SRC_DATA;
                    n_state = (n_rem == 8'd0) ? S_HDR : S_BYTE;
                end
            end else begin
                n_state = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= 6'd0;
            r_src   <= SRC_PRE;
            r_k     <= 3'd0;
            r_pos   <= 17'd0;
            r_rem   <= 8'd0;
            r_sum   <= 8'd0;
            r_cnt   <= 6'd0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_src   <= n_src;
            r_k     <= n_k;
            r_pos   <= n_pos;
            r_rem   <= n_rem;
            r_sum   <= n_sum;
            r_cnt   <= n_cnt;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_out_free) begin
            r_ovalid <= w_adv && !w_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && !w_drop) begin
            r_obyte <= w_emit;
            r_olast <= w_step_last || (r_cnt == LAST_RESULT);
            r_oend  <= w_is_end;
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.out_byte    = r_obyte;
    assign o_out.last_of_run = r_olast;
    assign o_out.tape_end    = r_oend;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAX_RESULTS)
        else $error("result count past limit");

    a_byte_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BYTE) |-> (r_rem != 8'd0))
        else $error("data byte with no open block");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_oend) |-> r_olast)
        else $error("end of tape not flagged as last of run");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_q_valid)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import cff_pkg::*;

    localparam int IDLE_PCT      = 28;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 100;
    localparam int ITEM_TARGET   = 280;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       tape_end;
    } tape_byte_t;

    class tape_scoreboard;
        t_cfg       regs;
        bit         file_open;
        bit [16:0]  position;
        bit [7:0]   owed;
        bit [7:0]   block_chk;
        tape_byte_t step_bytes[$];
        tape_byte_t expected_tape[$];
        int         errors;

        function new();
            regs      = CFG_RESET;
            file_open = 1'b0;
            position  = '0;
            owed      = '0;
            block_chk = '0;
            errors    = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [63:0] value);
            case (idx)
                REG_LOAD_ADDRESS: regs.load_address = value[15:0];
                REG_PAYLOAD_SIZE: regs.payload_size = value[15:0];
                REG_NAME_HEAD:    regs.name_head    = value;
                REG_NAME_TAIL:    regs.name_tail    = value[23:0];
                REG_FILE_TYPE:    regs.file_type    = value[1:0];
                default: ;
            endcase
        endfunction

        function logic [15:0] file_size();
            return (regs.payload_size == 16'd0) ? 16'd1 : regs.payload_size;
        endfunction

        function logic [7:0] sync_at(int i);
            if (i == 0)
                return SYNC_LEAD;
            if (i == 12)
                return SYNC_MARK;
            if (i == 13)
                return SYNC_TAIL;
            return SYNC_FILL;
        endfunction

        function void emit(logic [7:0] b, logic end_flag = 1'b0);
            if (step_bytes.size() < MAX_RESULTS)
                step_bytes.push_back('{out_byte: b, last_of_run: 1'b0, tape_end: end_flag});
        endfunction

        // needed: bytes certain to follow in the stream, this one included
        function void frame_byte(logic [7:0] b, int unsigned needed);
            int unsigned total;
            int unsigned len;
            if (owed == 0) begin
                total = file_size() + 10;
                if (position + needed > total)
                    total = position + needed;
                len = total - position;
                if (len > MAX_BLOCK_DATA)
                    len = MAX_BLOCK_DATA;
                for (int i = 2; i < 14; i++)
                    emit(sync_at(i));
                emit(BLK_DATA);
                emit(len[7:0]);
                block_chk = len[7:0] + 8'd1;
                owed      = len[7:0];
            end
            emit(b);
            block_chk += b;
            owed--;
            position++;
            if (owed == 0)
                emit(block_chk);
        endfunction

        function void note_payload_byte(logic [7:0] data);
            logic [15:0] size;
            logic [87:0] name_bytes;
            logic [7:0]  name_chk;
            logic [7:0]  c;
            logic [7:0]  frame [5];
            size = file_size();
            step_bytes.delete();
            if (!file_open) begin
                for (int i = 0; i < 14; i++)
                    emit(sync_at(i));
                emit(BLK_NAME);
                emit(NAME_LEN);
                name_chk   = NAME_LEN;
                name_bytes = {regs.name_head, regs.name_tail};
                for (int i = 0; i < 11; i++) begin
                    c = name_bytes[87 - 8 * i -: 8];
                    emit(c);
                    name_chk += c;
                end
                emit({6'd0, regs.file_type});
                emit(8'h00);
                emit(8'hFF);
                name_chk = name_chk + regs.file_type + 8'hFF;
                for (int i = 0; i < 6; i++)
                    emit(8'h00);
                emit(name_chk);
                file_open = 1'b1;
                position  = '0;
                owed      = '0;
                block_chk = '0;
                frame = '{8'h00, size[15:8], size[7:0],
                          regs.load_address[15:8], regs.load_address[7:0]};
                for (int k = 0; k < 5; k++)
                    frame_byte(frame[k], 11 - k);
            end
            frame_byte(data, 6);
            if (position >= size + 5) begin
                frame = '{8'hFF, 8'h00, 8'h00,
                          regs.load_address[15:8], regs.load_address[7:0]};
                for (int k = 0; k < 5; k++)
                    frame_byte(frame[k], 5 - k);
                while (owed != 0)
                    frame_byte(8'h00, 1);
                for (int i = 0; i < 14; i++)
                    emit(sync_at(i));
                emit(BLK_END);
                emit(8'h00);
                emit(8'hFF, 1'b1);
                file_open = 1'b0;
                position  = '0;
                owed      = '0;
                block_chk = '0;
            end
            if (step_bytes.size() > 0)
                step_bytes[$].last_of_run = 1'b1;
            foreach (step_bytes[i])
                expected_tape.push_back(step_bytes[i]);
        endfunction

        function void check_tape_byte(tape_byte_t got);
            tape_byte_t want;
            if (expected_tape.size() == 0) begin
                $error("out_byte %02h arrived with nothing pending", got.out_byte);
                errors++;
            end else begin
                want = expected_tape.pop_front();
                if (got.out_byte !== want.out_byte) begin
                    $error("out_byte expected %02h actual %02h", want.out_byte, got.out_byte);
                    errors++;
                end
                if (got.last_of_run !== want.last_of_run) begin
                    $error("last_of_run expected %0b actual %0b",
                           want.last_of_run, got.last_of_run);
                    errors++;
                end
                if (got.tape_end !== want.tape_end) begin
                    $error("tape_end expected %0b actual %0b", want.tape_end, got.tape_end);
                    errors++;
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    cff_in_if  in_if();
    cff_out_if out_if();
    cff_cfg_if cfg_if();

    cassette_file_framer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    tape_scoreboard tape_sb;
    bit steady      = 1'b0;
    int sent_items  = 0;
    int quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            tape_sb.check_tape_byte('{out_byte: out_if.out_byte,
                                      last_of_run: out_if.last_of_run,
                                      tape_end: out_if.tape_end});
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_payload_byte(input logic [7:0] data);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.data_byte <= data;
        do @(posedge i_clk); while (!in_if.ready);
        tape_sb.note_payload_byte(data);
        sent_items++;
        @(negedge i_clk);
    endtask

    // hold off until the whole image has come out
    task automatic drain_tape();
        in_if.valid <= 1'b0;
        while (tape_sb.expected_tape.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        tape_sb.set_reg(idx, value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_file(input int resize_pct);
        int done;
        done = 0;
        do begin
            if (done > 0 && $urandom_range(0, 99) < resize_pct) begin
                drain_tape();
                if ($urandom_range(0, 1))
                    write_reg(REG_LOAD_ADDRESS, 64'($urandom_range(0, 16'hFFFF)));
                write_reg(REG_PAYLOAD_SIZE, 64'($urandom_range(1, done + 12)));
            end
            push_payload_byte(8'($urandom_range(0, 255)));
            done++;
        end while (tape_sb.file_open);
    endtask

    function automatic logic [15:0] pick_size();
        int unsigned r;
        r = $urandom_range(0, 59);
        if (r < 45 || sent_items > ITEM_TARGET - 60)
            return 16'($urandom_range(1, 12));
        if (r < 57)
            return 16'($urandom_range(13, 40));
        if (r < 59)
            return 16'd0;
        return 16'($urandom_range(216, 230));
    endfunction

    task automatic reconfigure(input logic [15:0] size);
        int unsigned r;
        drain_tape();
        r = $urandom_range(0, 5);
        if ($urandom_range(0, 1))
            write_reg(REG_LOAD_ADDRESS, (r == 0) ? 64'h0 : (r == 1) ? 64'hFFFF
                                                 : 64'($urandom_range(0, 16'hFFFF)));
        if ($urandom_range(0, 1))
            write_reg(REG_NAME_HEAD, {$urandom, $urandom});
        if ($urandom_range(0, 1))
            write_reg(REG_NAME_TAIL, 64'($urandom_range(0, 24'hFFFFFF)));
        if ($urandom_range(0, 1))
            write_reg(REG_FILE_TYPE, 64'($urandom_range(0, 3)));
        write_reg(REG_PAYLOAD_SIZE, 64'(size));
    endtask

    initial begin
        tape_sb          = new();
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.data_byte  = 8'h00;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = REG_LOAD_ADDRESS;
        cfg_if.data      = 64'h0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_payload_byte(8'h00);
        drain_tape();
        write_reg(REG_LOAD_ADDRESS, 64'hFFFF);
        write_reg(REG_PAYLOAD_SIZE, 64'h0);
        write_reg(REG_NAME_HEAD, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_NAME_TAIL, 64'hFF_FFFF);
        write_reg(REG_FILE_TYPE, 64'd3);
        push_payload_byte(8'hFF);
        drain_tape();
        write_reg(REG_LOAD_ADDRESS, 64'h0);
        write_reg(REG_PAYLOAD_SIZE, 64'd2);
        write_reg(REG_NAME_HEAD, 64'h0);
        write_reg(REG_NAME_TAIL, 64'h0);
        write_reg(REG_FILE_TYPE, 64'd0);
        push_payload_byte(8'h00);
        push_payload_byte(8'hFF);
        drain_tape();
        write_reg(REG_PAYLOAD_SIZE, 64'hFFFF);
        write_reg(REG_FILE_TYPE, 64'd1);
        write_reg(REG_NAME_HEAD, 64'h4142_4344_4546_4748);
        push_payload_byte(8'hA5);
        push_payload_byte(8'h5A);
        push_payload_byte(8'h3C);
        drain_tape();
        write_reg(REG_PAYLOAD_SIZE, 64'd2);
        push_payload_byte(8'hF0);
        drain_tape();
        write_reg(REG_PAYLOAD_SIZE, 64'd65525);
        write_reg(REG_LOAD_ADDRESS, 64'h1234);
        push_payload_byte(8'h0F);
        push_payload_byte(8'h81);
        drain_tape();
        write_reg(REG_PAYLOAD_SIZE, 64'd6);
        send_file(0);
        drain_tape();
        write_reg(REG_PAYLOAD_SIZE, 64'd4);
        write_reg(REG_FILE_TYPE, 64'd2);
        push_payload_byte(8'h7E);
        push_payload_byte(8'hC3);
        drain_tape();
        write_reg(REG_PAYLOAD_SIZE, 64'd10);
        send_file(0);

        reconfigure(16'($urandom_range(216, 230)));
        while (sent_items < ITEM_TARGET) begin
            steady = (sent_items >= 120 && sent_items < 180);
            if ($urandom_range(0, 1))
                reconfigure(pick_size());
            send_file(($urandom_range(0, 3) == 0) ? 15 : 0);
        end
        steady = 1'b0;
        drain_tape();

        if (tape_sb.errors == 0 && tape_sb.expected_tape.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
design/cff_pkg.sv
design/cff_if.sv
design/cff_front.sv
design/cff_queue.sv
design/cff_back.sv
design/cassette_file_framer.sv
tb/testbench.sv
